/* rtl/core/lzwd_pkg.sv */
// ----------------------------------------------------------------------------
// lzwd_pkg
// shared types and constants for the lzw decoder
// ----------------------------------------------------------------------------
`default_nettype none
package lzwd_pkg;
    typedef struct packed {
        logic       mode;
        logic [7:0] in_byte;
    } t_in;

    typedef struct packed {
        logic       out_valid;
        logic [7:0] out_byte;
        logic       last;
        logic       need_byte;
        logic [2:0] status;
    } t_out;

    localparam logic [2:0] ST_RUN  = 3'd0;
    localparam logic [2:0] ST_DONE = 3'd1;
    localparam logic [2:0] ST_LONG = 3'd2;
    localparam logic [2:0] ST_ZERO = 3'd3;
    localparam logic [2:0] ST_OVF  = 3'd4;
endpackage
`default_nettype wire

/* rtl/core/lzw_variable_width_decoder_top.sv */
// ----------------------------------------------------------------------------
// lzw_variable_width_decoder_top
// gif style lzw decoder, 9 to 12 bit codes, lsb first
// ----------------------------------------------------------------------------
// channel | direction | handshake           | payload
// input   | in        | i_valid / o_ready   | i_data  (mode, in_byte)
// output  | out       | o_valid / i_ready   | o_data  (out_valid .. status)
// config  | in        | i_cfg_we            | i_cfg_data (output_length)
//
// a byte beat passes S_IDLE and S_POPD; a pop beat passes S_FETCH per
// code fetched, S_WALK, S_RD and S_PUSH per string symbol walked (one
// dictionary read each), then S_POP and S_POPD. synchronous active-low reset,
// no clearing pass: tables are only read where written. a two-entry queue
// lets the front take beats while the back is stalled on the output register
`default_nettype none
module lzw_variable_width_decoder_top #(
    parameter int ROOT_BITS     = 8,
    parameter int MAX_CODE_BITS = 12,
    parameter int DICT_DEPTH    = 4096,
    parameter int STACK_DEPTH   = 2048
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_we,
    input  wire logic [23:0]    i_cfg_data,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire lzwd_pkg::t_in  i_data,
    output logic                o_valid,
    input  wire logic           i_ready,
    output lzwd_pkg::t_out      o_data
);
    logic [23:0]   r_len;
    logic          w_qv, w_qr;
    lzwd_pkg::t_in w_qd;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_len <= '0;
        else if (i_cfg_we) r_len <= i_cfg_data;
    end

    // front: queue of accepted beats
    lzwd_fifo u_fifo (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_data,
        .o_valid(w_qv), .i_ready(w_qr), .o_data(w_qd)
    );

    // back: decoding engine
    lzwd_core #(
        .ROOT_BITS(ROOT_BITS), .MAX_CODE_BITS(MAX_CODE_BITS),
        .DICT_DEPTH(DICT_DEPTH), .STACK_DEPTH(STACK_DEPTH)
    ) u_core (
        .i_clk, .i_rst_n, .i_len(r_len),
        .i_valid(w_qv), .o_ready(w_qr), .i_data(w_qd),
        .o_valid, .i_ready, .o_data
    );

    // a result that carries a byte never has need_byte set on the final beat
    a_nodata: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.out_valid |-> !o_data.need_byte || !o_data.last)
        else $error("need_byte on final beat");
    // finished results never have need_byte set
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.last |-> !o_data.need_byte)
        else $error("need_byte after end");
endmodule
`default_nettype wire

/* rtl/core/lzwd_fifo.sv */
// ----------------------------------------------------------------------------
// lzwd_fifo
// two-entry queue between the front and the back of the decoder
// ----------------------------------------------------------------------------
`default_nettype none
module lzwd_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire lzwd_pkg::t_in i_data,
    output logic               o_valid,
    input  wire logic          i_ready,
    output lzwd_pkg::t_in      o_data
);
    lzwd_pkg::t_in r_mem [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_valid && o_ready) begin
                r_mem[r_wp] <= i_data;
                r_wp        <= ~r_wp;
            end
            if (o_valid && i_ready) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_valid && o_ready) - 2'(o_valid && i_ready);
        end
    end
endmodule
`default_nettype wire

/* rtl/core/lzwd_core.sv */
// ----------------------------------------------------------------------------
// lzwd_core
// bit buffer, code fetch, dictionary walk, stack pop and output register
// ----------------------------------------------------------------------------
`default_nettype none
module lzwd_core #(
    parameter int ROOT_BITS     = 8,
    parameter int MAX_CODE_BITS = 12,
    parameter int DICT_DEPTH    = 4096,
    parameter int STACK_DEPTH   = 2048
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [23:0]   i_len,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire lzwd_pkg::t_in i_data,
    output logic               o_valid,
    input  wire logic          i_ready,
    output lzwd_pkg::t_out     o_data
);
    localparam int CW  = MAX_CODE_BITS;
    localparam int DAW = $clog2(DICT_DEPTH);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int SCW = $clog2(STACK_DEPTH + 1);
    localparam int NFW = DAW + 1;
    localparam int WW  = $clog2(MAX_CODE_BITS + 1);
    localparam logic [CW-1:0] RMASK = CW'((1 << ROOT_BITS) - 1);
    localparam logic [CW-1:0] CLR   = CW'(1 << ROOT_BITS);
    localparam logic [CW-1:0] ENDC  = CW'((1 << ROOT_BITS) + 1);
    localparam logic [NFW-1:0] FREE0 = NFW'((1 << ROOT_BITS) + 2);
    localparam logic [WW-1:0] W0    = WW'(ROOT_BITS + 1);

    typedef enum logic [2:0] {S_IDLE, S_FETCH, S_WALK, S_RD, S_PUSH, S_POP, S_POPD}
        t_state;

    t_state          r_st;
    logic [31:0]     r_buf;
    logic [5:0]      r_bits;
    logic [WW-1:0]   r_w;
    logic [NFW-1:0]  r_nf;
    logic [CW-1:0]   r_prev, r_code, r_cur;
    logic [7:0]      r_first;
    logic [23:0]     r_wr;
    logic            r_done, r_fresh;
    logic [2:0]      r_fin;
    logic [SCW-1:0]  r_sc;
    logic [3:0]      r_guard;
    logic            r_ovalid;
    lzwd_pkg::t_out  r_out;

    logic [DAW-1:0]  r_pre [DICT_DEPTH];
    logic [7:0]      r_suf [DICT_DEPTH];
    logic [7:0]      r_stk [STACK_DEPTH];
    logic [CW-1:0]   r_pre_q;
    logic [7:0]      r_suf_q, r_stk_q;

    logic [CW-1:0]   w_code;
    logic [CW-1:0]   w_mask;
    logic            w_need;

    assign w_mask  = CW'((1 << r_w) - 1);
    assign w_code  = r_buf[CW-1:0] & w_mask;
    assign w_need  = !r_done && (r_bits < 6'(r_w));
    assign o_ready = (r_st == S_IDLE) && !r_ovalid;
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        r_pre_q <= CW'(r_pre[r_cur[DAW-1:0]]);
        r_suf_q <= r_suf[r_cur[DAW-1:0]];
        r_stk_q <= r_stk[SAW'(r_sc - SCW'(1))];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_buf <= '0; r_bits <= '0; r_w <= W0; r_nf <= FREE0;
            r_prev <= '0; r_first <= '0; r_wr <= '0; r_done <= 1'b0;
            r_fresh <= 1'b1; r_fin <= lzwd_pkg::ST_RUN; r_sc <= '0;
            r_ovalid <= 1'b0; r_guard <= '0;
        end else begin
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            unique case (r_st)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_out <= '0;
                        if (r_done) begin
                            r_out.last <= 1'b1; r_out.status <= r_fin; r_ovalid <= 1'b1;
                        end else if (!i_data.mode) begin
                            if (r_bits > 6'd24) r_out.status <= lzwd_pkg::ST_OVF;
                            else begin
                                r_buf  <= r_buf | (32'(i_data.in_byte) << r_bits);
                                r_bits <= r_bits + 6'd8;
                            end
                            r_st <= S_POPD;
                        end else if (i_len == '0) begin
                            r_done <= 1'b1; r_fin <= lzwd_pkg::ST_ZERO; r_sc <= '0;
                            r_out.last <= 1'b1; r_out.status <= lzwd_pkg::ST_ZERO;
                            r_ovalid <= 1'b1;
                        end else if (r_wr >= i_len) begin
                            r_done <= 1'b1; r_fin <= lzwd_pkg::ST_DONE; r_sc <= '0;
                            r_out.last <= 1'b1; r_out.status <= lzwd_pkg::ST_DONE;
                            r_ovalid <= 1'b1;
                        end else begin
                            r_guard <= '0;
                            r_st <= (r_sc != '0) ? S_POP : S_FETCH;
                        end
                    end
                end
                S_FETCH: begin
                    if (r_guard == 4'd8 || r_bits < 6'(r_w)) r_st <= S_POPD;
                    else begin
                        r_guard <= r_guard + 4'd1;
                        r_buf   <= r_buf >> r_w;
                        r_bits  <= r_bits - 6'(r_w);
                        r_code  <= w_code;
                        if (w_code == CLR) begin
                            r_w <= W0; r_nf <= FREE0; r_fresh <= 1'b1;
                        end else if (w_code == ENDC) begin
                            r_done <= 1'b1; r_fin <= lzwd_pkg::ST_DONE; r_sc <= '0;
                            r_st <= S_POPD;
                        end else if (r_fresh) begin
                            r_fresh <= 1'b0;
                            r_first <= 8'(w_code & RMASK);
                            r_prev  <= w_code;
                            r_stk[0] <= 8'(w_code & RMASK);
                            r_sc <= SCW'(1);
                            r_st <= S_POP;
                        end else if (NFW'(w_code) >= r_nf) begin
                            r_stk[0] <= r_first; r_sc <= SCW'(1);
                            r_cur <= r_prev; r_st <= S_WALK;
                        end else begin
                            r_cur <= w_code; r_st <= S_WALK;
                        end
                    end
                end
                S_WALK: begin
                    if (r_cur > RMASK) r_st <= S_RD;
                    else if (r_sc >= SCW'(STACK_DEPTH)) begin
                        r_done <= 1'b1; r_fin <= lzwd_pkg::ST_LONG; r_sc <= '0;
                        r_st <= S_POPD;
                    end else begin
                        r_first <= 8'(r_cur & RMASK);
                        r_stk[SAW'(r_sc)] <= 8'(r_cur & RMASK);
                        r_sc <= r_sc + SCW'(1);
                        if (r_nf < NFW'(DICT_DEPTH)) begin
                            r_pre[r_nf[DAW-1:0]] <= DAW'(r_prev);
                            r_suf[r_nf[DAW-1:0]] <= 8'(r_cur & RMASK);
                            r_nf <= r_nf + NFW'(1);
                            if ((r_nf + NFW'(1)) >= NFW'(1 << r_w) && r_w < WW'(CW))
                                r_w <= r_w + WW'(1);
                        end
                        r_prev <= r_code;
                        r_st <= S_POP;
                    end
                end
                S_RD: r_st <= S_PUSH;
                S_PUSH: begin
                    if (r_sc >= SCW'(STACK_DEPTH)) begin
                        r_done <= 1'b1; r_fin <= lzwd_pkg::ST_LONG; r_sc <= '0;
                        r_st <= S_POPD;
                    end else begin
                        r_stk[SAW'(r_sc)] <= r_suf_q;
                        r_sc  <= r_sc + SCW'(1);
                        r_cur <= r_pre_q;
                        r_st  <= S_WALK;
                    end
                end
                S_POP: begin
                    // read stack top, result finished next cycle
                    r_sc <= r_sc - SCW'(1);
                    r_out.out_valid <= 1'b1;
                    r_wr <= r_wr + 24'd1;
                    r_st <= S_POPD;
                end
                S_POPD: begin
                    if (r_out.out_valid) begin
                        r_out.out_byte <= r_stk_q;
                        if (r_wr >= i_len) begin
                            r_done <= 1'b1; r_fin <= lzwd_pkg::ST_DONE; r_sc <= '0;
                        end
                    end
                    r_st <= S_IDLE;
                    r_ovalid <= 1'b1;
                end
                default: r_st <= S_IDLE;
            endcase
            if (r_st == S_POPD) begin
                // finalise flags from the settled state
                if (r_done || (r_out.out_valid && r_wr >= i_len)) begin
                    r_out.last <= 1'b1;
                    if (r_out.status != lzwd_pkg::ST_OVF)
                        r_out.status <= r_done ? r_fin : lzwd_pkg::ST_DONE;
                    r_out.need_byte <= 1'b0;
                end else r_out.need_byte <= w_need;
            end
        end
    end
    // stack read address tracks count; pop reads slot count-1 in S_POP
    logic unused_ok;
    assign unused_ok = ^r_suf_q[0];
endmodule
`default_nettype wire
